>>> rtl/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// types and codes shared by the free list block allocator
// ----------------------------------------------------------------------------
package fla_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int INDEX_W     = 8;
   localparam int COUNT_W     = 9;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_BLOCKS = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;

   localparam logic [COUNT_W-1:0] RETURNED_MAX = 9'h1ff;

   typedef struct packed {
      logic               op;
      logic [INDEX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] granted_index;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic               we;
      logic [INDEX_W-1:0] waddr;
      logic [INDEX_W-1:0] wdata;
      logic               re;
      logic [INDEX_W-1:0] raddr;
   } ram_req_type;

endpackage

>>> rtl/fla_link_ram.sv
// ----------------------------------------------------------------------------
// fla_link_ram
// link memory of the free list, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fla_link_ram #(
   parameter int DEPTH = 256
) (
   input  logic                      clock,
   input  fla_pkg::ram_req_type      ram_req,
   output logic [fla_pkg::INDEX_W-1:0] rdata
);
   import fla_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [INDEX_W-1:0] mem [DEPTH];
   logic [INDEX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr[AW-1:0]] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rdata_ff <= mem[ram_req.raddr[AW-1:0]];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/fla_core.sv
// ----------------------------------------------------------------------------
// fla_core
// head, counters and result register of the free list allocator
// ----------------------------------------------------------------------------
module fla_core #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  fla_pkg::req_type            req_payload,
   input  logic                        csr_write,
   input  logic [fla_pkg::COUNT_W-1:0] csr_data,
   input  logic [fla_pkg::INDEX_W-1:0] ram_rdata,
   output fla_pkg::ram_req_type        ram_req,
   output logic                        rsp_valid,
   output fla_pkg::rsp_type            rsp_payload
);
   import fla_pkg::*;

   localparam int POOL_LIMIT = (MAX_BLOCKS < TABLE_DEPTH) ? MAX_BLOCKS : TABLE_DEPTH;
   localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(POOL_LIMIT);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] fresh_ff, fresh_in;
   logic [COUNT_W-1:0] returned_ff, returned_in;
   logic [INDEX_W-1:0] head_ff, head_in;
   logic [INDEX_W-1:0] saved_ff, saved_in;
   logic               src_ram_ff, src_ram_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [INDEX_W-1:0] next_head;
   logic [COUNT_W-1:0] clamped;

   assign next_head = src_ram_ff ? ram_rdata : saved_ff;

   always_comb begin
      clamped = csr_data;
      if (clamped == '0) begin
         clamped = COUNT_W'(1);
      end
      if (clamped > LIMIT) begin
         clamped = LIMIT;
      end
   end

   always_comb begin
      count_in     = count_ff;
      fresh_in     = fresh_ff;
      returned_in  = returned_ff;
      head_in      = head_ff;
      saved_in     = saved_ff;
      src_ram_in   = src_ram_ff;
      rsp_valid_in = accept;
      rsp_in       = rsp_ff;
      ram_req      = '0;
      if (csr_write) begin
         count_in    = clamped;
         fresh_in    = '0;
         returned_in = '0;
         head_in     = '0;
      end else if (accept) begin
         rsp_in.granted_index = '0;
         rsp_in.status        = STATUS_OK;
         if (req_payload.op == OP_ALLOC) begin
            if (returned_ff != '0) begin
               rsp_in.granted_index = head_ff;
               head_in       = next_head;
               ram_req.re    = 1'b1;
               ram_req.raddr = next_head;
               src_ram_in    = 1'b1;
               returned_in   = returned_ff - COUNT_W'(1);
            end else if (fresh_ff < count_ff) begin
               rsp_in.granted_index = fresh_ff[INDEX_W-1:0];
               fresh_in = fresh_ff + COUNT_W'(1);
            end else begin
               rsp_in.status = STATUS_NO_BLOCKS;
            end
         end else begin
            if ({1'b0, req_payload.block_index} >= count_ff) begin
               rsp_in.status = STATUS_RANGE;
            end else begin
               ram_req.we    = 1'b1;
               ram_req.waddr = req_payload.block_index;
               ram_req.wdata = head_ff;
               head_in       = req_payload.block_index;
               saved_in      = head_ff;
               src_ram_in    = 1'b0;
               if (returned_ff != RETURNED_MAX) begin
                  returned_in = returned_ff + COUNT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= LIMIT;
         fresh_ff     <= '0;
         returned_ff  <= '0;
         head_ff      <= '0;
         src_ram_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         returned_ff  <= returned_in;
         head_ff      <= head_in;
         src_ram_ff   <= src_ram_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      saved_ff <= saved_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/free_list_block_allocator.sv
// ----------------------------------------------------------------------------
// free_list_block_allocator
// fixed pool of equal blocks on a lifo free list, blocks named by index
// ----------------------------------------------------------------------------
// Each edge with start high and csr_valid low takes a command; busy is low, so
// one allocate or free can be issued every cycle. Each command gives exactly
// one result beat, on rsp_valid one cycle after the command was taken, held
// for that single cycle only: the receiver must take it then. The one-cycle
// rate is set by the head register and the link memory: the successor of the
// current head is held either by the registered read of the link memory or,
// just after a free, by a saved copy of the previous head. No clearing pass
// is needed after reset or a block count write.
module free_list_block_allocator #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  fla_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   output fla_pkg::rsp_type            rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [fla_pkg::COUNT_W-1:0] csr_data
);
   import fla_pkg::*;

   localparam int POOL_LIMIT = (MAX_BLOCKS < TABLE_DEPTH) ? MAX_BLOCKS : TABLE_DEPTH;

   ram_req_type        ram_req;
   logic [INDEX_W-1:0] ram_rdata;
   logic               accept;
   logic               csr_write;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;
   assign csr_write = csr_valid & csr_ready;

   fla_core #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .csr_write   (csr_write),
      .csr_data    (csr_data),
      .ram_rdata   (ram_rdata),
      .ram_req     (ram_req),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   fla_link_ram #(
      .DEPTH (POOL_LIMIT)
   ) u_link_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (ram_rdata)
   );

endmodule

>>> bench/free_list_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// free_list_block_allocator_tb
// Drives allocate and free commands into the block allocator and checks
// every result beat against an in-bench model of the free list: head, links,
// returned count and the next block never granted. A short table of directed
// commands comes first, then random phases with a new pool size each, and one
// long run of frees that saturates the returned count.
// ----------------------------------------------------------------------------
module free_list_block_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fla_pkg::*;

   localparam int POOL_MAX    = 256;
   localparam int CYCLE_LIMIT = 40000;
   localparam int RANDOM_GOAL = 200;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [COUNT_W-1:0] csr_value;
      logic               op;
      logic [INDEX_W-1:0] index;
      logic               typed;
      logic [INDEX_W-1:0] grant;
      logic [1:0]         status;
   } row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_payload;
   logic               rsp_valid;
   rsp_type            rsp_payload;
   logic               csr_valid;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data;

   logic [INDEX_W-1:0] next_link [TABLE_DEPTH];
   logic [INDEX_W-1:0] list_head;
   logic [COUNT_W-1:0] returned_len;
   logic [COUNT_W-1:0] fresh_next;
   logic [COUNT_W-1:0] pool_size;

   rsp_type            outcomes_due [$];
   logic [INDEX_W-1:0] granted_blocks [$];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   bit                 steady = 0;

   row_type directed_rows [0:30] = '{
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h00, 1'b1, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'hff, 1'b1, 8'h01, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_FREE,  8'hff, 1'b1, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h00, 1'b1, 8'hff, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_FREE,  8'h00, 1'b1, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_FREE,  8'h00, 1'b1, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'haa, 1'b1, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h55, 1'b1, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h00, 1'b1, 8'h02, STATUS_OK},
      '{ROW_CSR,  9'd0,   OP_ALLOC, 8'h00, 1'b0, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h00, 1'b1, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h00, 1'b1, 8'h00, STATUS_NO_BLOCKS},
      '{ROW_ITEM, 9'd0,   OP_FREE,  8'h01, 1'b1, 8'h00, STATUS_RANGE},
      '{ROW_ITEM, 9'd0,   OP_FREE,  8'hff, 1'b1, 8'h00, STATUS_RANGE},
      '{ROW_ITEM, 9'd0,   OP_FREE,  8'h00, 1'b1, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h00, 1'b1, 8'h00, STATUS_OK},
      '{ROW_CSR,  9'd511, OP_ALLOC, 8'h00, 1'b0, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_FREE,  8'hff, 1'b1, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h00, 1'b1, 8'hff, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h00, 1'b1, 8'h00, STATUS_OK},
      '{ROW_CSR,  9'd257, OP_ALLOC, 8'h00, 1'b0, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_FREE,  8'h80, 1'b0, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_FREE,  8'h07, 1'b0, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h00, 1'b0, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h00, 1'b0, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h00, 1'b0, 8'h00, STATUS_OK},
      '{ROW_CSR,  9'd2,   OP_ALLOC, 8'h00, 1'b0, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_FREE,  8'h02, 1'b1, 8'h00, STATUS_RANGE},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'hff, 1'b0, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h00, 1'b0, 8'h00, STATUS_OK},
      '{ROW_ITEM, 9'd0,   OP_ALLOC, 8'h00, 1'b1, 8'h00, STATUS_NO_BLOCKS}
   };

   free_list_block_allocator #(
      .MAX_BLOCKS(POOL_MAX)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic void empty_pool(input logic [COUNT_W-1:0] count);
      pool_size = count;
      if (pool_size == 0) pool_size = COUNT_W'(1);
      if (pool_size > POOL_MAX) pool_size = COUNT_W'(POOL_MAX);
      if (pool_size > TABLE_DEPTH) pool_size = COUNT_W'(TABLE_DEPTH);
      foreach (next_link[i]) next_link[i] = '0;
      list_head    = '0;
      returned_len = '0;
      fresh_next   = '0;
   endfunction

   function automatic rsp_type pool_outcome(input logic op, input logic [INDEX_W-1:0] index);
      rsp_type r;
      r = '0;
      r.status = STATUS_OK;
      if (op == OP_ALLOC) begin
         if (returned_len != 0) begin
            r.granted_index = list_head;
            list_head = next_link[list_head];
            returned_len--;
         end else if (fresh_next < pool_size) begin
            r.granted_index = fresh_next[INDEX_W-1:0];
            fresh_next++;
         end else begin
            r.status = STATUS_NO_BLOCKS;
         end
      end else if ({1'b0, index} >= pool_size) begin
         r.status = STATUS_RANGE;
      end else begin
         next_link[index] = list_head;
         list_head = index;
         if (returned_len != RETURNED_MAX) returned_len++;
      end
      return r;
   endfunction

   // stop issuing and let every outstanding result beat arrive
   task automatic drain_results();
      @(negedge clock) start <= 1'b0;
      while (outcomes_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] value);
      drain_results();
      repeat (2) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      empty_pool(value);
      granted_blocks.delete();
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic send_item(input logic op, input logic [INDEX_W-1:0] index,
                            input logic typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type due;
      gap = steady ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       <= 1'b1;
      req_payload <= '{op: op, block_index: index};
      do @(posedge clock); while (busy !== 1'b0);
      due = pool_outcome(op, index);
      if (op == OP_ALLOC && due.status == STATUS_OK) granted_blocks.push_back(due.granted_index);
      outcomes_due.push_back(typed ? typed_rsp : due);
   endtask

   task automatic send_free_of_held();
      int                 k;
      logic [INDEX_W-1:0] index;
      if (granted_blocks.size() == 0) begin
         index = INDEX_W'($urandom_range(0, pool_size - 1));
      end else begin
         k = $urandom_range(0, granted_blocks.size() - 1);
         index = granted_blocks[k];
         granted_blocks.delete(k);
      end
      send_item(OP_FREE, index, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type due;
      if (!reset && rsp_valid === 1'b1) begin
         if (outcomes_due.size() == 0) begin
            flag_mismatch($sformatf("result beat with nothing expected, index %0d status %0d",
                                    rsp_payload.granted_index, rsp_payload.status));
         end else begin
            due = outcomes_due.pop_front();
            if (rsp_payload.granted_index !== due.granted_index)
               flag_mismatch($sformatf("granted_index %0d, expected %0d",
                                       rsp_payload.granted_index, due.granted_index));
            if (rsp_payload.status !== due.status)
               flag_mismatch($sformatf("status %0d, expected %0d",
                                       rsp_payload.status, due.status));
         end
      end
   end

   initial begin : stimulus
      int                 random_items;
      int                 phase_len;
      int                 roll;
      int                 w;
      logic [COUNT_W-1:0] count;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      empty_pool(COUNT_W'(TABLE_DEPTH));
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_count(directed_rows[i].csr_value);
         else
            send_item(directed_rows[i].op, directed_rows[i].index, directed_rows[i].typed,
                      '{granted_index: directed_rows[i].grant,
                        status: directed_rows[i].status});
      end

      random_items = 0;
      while (random_items < RANDOM_GOAL) begin
         case ($urandom_range(0, 5))
            0:       count = COUNT_W'(1);
            1:       count = COUNT_W'(TABLE_DEPTH);
            2:       count = COUNT_W'($urandom_range(0, 511));
            3:       count = COUNT_W'($urandom_range(1, 256));
            default: count = COUNT_W'($urandom_range(1, 16));
         endcase
         write_count(count);
         steady = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(20, 120);
         repeat (phase_len) begin
            if ($urandom_range(0, 60) == 0) drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 45)
               send_item(OP_ALLOC, INDEX_W'($urandom_range(0, 255)), 1'b0, '0);
            else if (roll < 82)
               send_free_of_held();
            else
               send_item(OP_FREE, INDEX_W'($urandom_range(0, 255)), 1'b0, '0);
            random_items++;
         end
      end

      // push past the returned count ceiling, then pop it all and exhaust the pool
      write_count(COUNT_W'($urandom_range(1, 24)));
      steady = 1'b0;
      repeat (515) send_item(OP_FREE, INDEX_W'($urandom_range(0, pool_size - 1)), 1'b0, '0);
      steady = 1'b1;
      repeat (540) send_item(OP_ALLOC, INDEX_W'($urandom_range(0, 255)), 1'b0, '0);

      @(negedge clock) start <= 1'b0;
      for (w = 0; w < 50 && outcomes_due.size() != 0; w++) @(negedge clock);
      if (outcomes_due.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));
      repeat (4) @(negedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> files.f
rtl/fla_pkg.sv
rtl/fla_link_ram.sv
rtl/fla_core.sv
rtl/free_list_block_allocator.sv
bench/free_list_block_allocator_tb.sv
